>>> rtl/core/hslrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Field widths, fixed-point constants, payload types and shared helpers.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = FRAC_BITS + 1;
	localparam int LVL_W     = FIELD_W + 3;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic signed [LVL_W-1:0] lvl_t;

	localparam field_t ONE   = field_t'(1) << FRAC_BITS;
	localparam field_t HALF  = field_t'(1) << (FRAC_BITS - 1);
	localparam field_t THIRD = field_t'((1 << FRAC_BITS) / 3);

	typedef struct packed {
		field_t hue;
		field_t saturation;
		field_t lightness;
	} hsl_t;

	typedef struct packed {
		field_t red;
		field_t green;
		field_t blue;
	} rgb_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} pipe_en_t;

	typedef enum logic [1:0] {
		ZONE_RISE = 2'd0,
		ZONE_HIGH = 2'd1,
		ZONE_FALL = 2'd2,
		ZONE_LOW  = 2'd3
	} zone_t;

	function automatic field_t sat_field(input field_t v);
		return (v > ONE) ? ONE : v;
	endfunction

	function automatic field_t clamp_unit(input lvl_t v);
		if (v < 0)
			return '0;
		if (v > $signed({3'b000, ONE}))
			return ONE;
		return v[FIELD_W-1:0];
	endfunction

endpackage

>>> rtl/core/hslrgb_level.sv
// ----------------------------------------------------------------------------
// HSL to RGB level unit
// Forms the high and low levels and their difference over two stages.
// ----------------------------------------------------------------------------
module hslrgb_level (
	input  logic                clk,
	input  hslrgb_pkg::pipe_en_t en,
	input  hslrgb_pkg::field_t  sat,
	input  hslrgb_pkg::field_t  light,
	output hslrgb_pkg::field_t  low_s2,
	output hslrgb_pkg::field_t  high_s2,
	output hslrgb_pkg::field_t  diff_s2
);
	import hslrgb_pkg::*;

	localparam int PROD_W = 2 * FIELD_W + 1;

	logic [FIELD_W:0]   mul_b;
	logic [PROD_W-1:0]  prod_s1;
	field_t             light_s1;
	field_t             sat_s1;
	logic               dark_s1;
	logic [FIELD_W:0]   prod_sh;
	lvl_t               high_raw;
	lvl_t               low_raw;
	field_t             high_c;
	field_t             low_c;
	field_t             high_f;

	always_comb begin
		mul_b = (light < HALF) ? ({1'b0, ONE} + {1'b0, sat}) : {1'b0, sat};
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1  <= PROD_W'({1'b0, light}) * PROD_W'(mul_b);
			light_s1 <= light;
			sat_s1   <= sat;
			dark_s1  <= light < HALF;
		end
	end

	always_comb begin
		prod_sh = prod_s1[FRAC_BITS +: FIELD_W + 1];
		if (dark_s1)
			high_raw = $signed({2'b00, prod_sh});
		else
			high_raw = $signed({3'b000, light_s1}) + $signed({3'b000, sat_s1})
				- $signed({2'b00, prod_sh});
		high_c  = clamp_unit(high_raw);
		low_raw = ($signed({3'b000, light_s1}) <<< 1) - $signed({3'b000, high_c});
		low_c   = clamp_unit(low_raw);
		high_f  = (high_c < low_c) ? low_c : high_c;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			low_s2  <= low_c;
			high_s2 <= high_f;
			diff_s2 <= high_f - low_c;
		end
	end

endmodule

>>> rtl/core/hslrgb_channel.sv
// ----------------------------------------------------------------------------
// HSL to RGB channel unit
// Maps one wrapped hue position to a zone and weight, scales the level
// difference by the weight and selects the channel level.
// ----------------------------------------------------------------------------
module hslrgb_channel (
	input  logic                 clk,
	input  hslrgb_pkg::pipe_en_t en,
	input  hslrgb_pkg::field_t   pos,
	input  hslrgb_pkg::field_t   low_s2,
	input  hslrgb_pkg::field_t   high_s2,
	input  hslrgb_pkg::field_t   diff_s2,
	output hslrgb_pkg::field_t   level_s4
);
	import hslrgb_pkg::*;

	localparam int TW     = FIELD_W + 3;
	localparam int PROD_W = 2 * FIELD_W;

	logic [TW-1:0]     pos_x;
	logic [TW-1:0]     pos2;
	logic [TW-1:0]     pos3;
	logic [TW-1:0]     pos6;
	logic [TW-1:0]     one_x;
	logic [TW-1:0]     fall_w;
	zone_t             zone_c;
	field_t            wgt_c;
	zone_t             zone_s1;
	zone_t             zone_s2;
	zone_t             zone_s3;
	field_t            wgt_s1;
	field_t            wgt_s2;
	logic [PROD_W-1:0] prod_s3;
	field_t            low_s3;
	field_t            high_s3;
	logic [FIELD_W:0]  ramp;

	always_comb begin
		pos_x  = {3'b000, pos};
		one_x  = TW'(ONE);
		pos2   = pos_x << 1;
		pos3   = pos2 + pos_x;
		pos6   = pos3 << 1;
		fall_w = (one_x << 2) - pos6;
		if (pos6 < one_x) begin
			zone_c = ZONE_RISE;
			wgt_c  = pos6[FIELD_W-1:0];
		end else if (pos2 < one_x) begin
			zone_c = ZONE_HIGH;
			wgt_c  = '0;
		end else if (pos3 < (one_x << 1)) begin
			zone_c = ZONE_FALL;
			wgt_c  = fall_w[FIELD_W-1:0];
		end else begin
			zone_c = ZONE_LOW;
			wgt_c  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			zone_s1 <= zone_c;
			wgt_s1  <= wgt_c;
		end
		if (en.s2) begin
			zone_s2 <= zone_s1;
			wgt_s2  <= wgt_s1;
		end
		if (en.s3) begin
			zone_s3 <= zone_s2;
			prod_s3 <= diff_s2 * wgt_s2;
			low_s3  <= low_s2;
			high_s3 <= high_s2;
		end
	end

	always_comb begin
		ramp = {1'b0, low_s3} + {1'b0, prod_s3[FRAC_BITS +: FIELD_W]};
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			case (zone_s3)
				ZONE_RISE: level_s4 <= ramp[FIELD_W-1:0];
				ZONE_HIGH: level_s4 <= high_s3;
				ZONE_FALL: level_s4 <= ramp[FIELD_W-1:0];
				ZONE_LOW:  level_s4 <= low_s3;
				default:   level_s4 <= low_s3;
			endcase
		end
	end

endmodule

>>> rtl/core/hsl_to_rgb_converter_unit.sv
// Throughput: one transaction per cycle; the four-stage pipeline with one
// multiplier per channel advances every cycle unless the output is stalled.
// A stalled stage holds while empty stages behind it keep filling.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Converts one pixel from hue, saturation and lightness to red, green, blue.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hsl_valid,
	output logic             hsl_ready,
	input  hslrgb_pkg::hsl_t hsl,
	output logic             rgb_valid,
	input  logic             rgb_ready,
	output hslrgb_pkg::rgb_t rgb
);
	import hslrgb_pkg::*;

	pipe_en_t         en;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             valid_s4;
	field_t           hue_c;
	field_t           sat_c;
	field_t           light_c;
	logic [FIELD_W:0] red_sum;
	field_t           pos_red;
	field_t           pos_blue;
	field_t           low_s2;
	field_t           high_s2;
	field_t           diff_s2;
	field_t           red_s4;
	field_t           green_s4;
	field_t           blue_s4;

	always_comb begin
		en.s4 = !valid_s4 || rgb_ready;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign hsl_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1)
				valid_s1 <= hsl_valid;
			if (en.s2)
				valid_s2 <= valid_s1;
			if (en.s3)
				valid_s3 <= valid_s2;
			if (en.s4)
				valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		hue_c    = sat_field(hsl.hue);
		sat_c    = sat_field(hsl.saturation);
		light_c  = sat_field(hsl.lightness);
		red_sum  = {1'b0, hue_c} + {1'b0, THIRD};
		pos_red  = (red_sum > {1'b0, ONE}) ? FIELD_W'(red_sum - {1'b0, ONE})
			: red_sum[FIELD_W-1:0];
		pos_blue = (hue_c < THIRD) ? FIELD_W'(hue_c + ONE - THIRD) : FIELD_W'(hue_c - THIRD);
	end

	hslrgb_level u_level (
		.clk     (clk),
		.en      (en),
		.sat     (sat_c),
		.light   (light_c),
		.low_s2  (low_s2),
		.high_s2 (high_s2),
		.diff_s2 (diff_s2)
	);

	hslrgb_channel u_red (
		.clk      (clk),
		.en       (en),
		.pos      (pos_red),
		.low_s2   (low_s2),
		.high_s2  (high_s2),
		.diff_s2  (diff_s2),
		.level_s4 (red_s4)
	);

	hslrgb_channel u_green (
		.clk      (clk),
		.en       (en),
		.pos      (hue_c),
		.low_s2   (low_s2),
		.high_s2  (high_s2),
		.diff_s2  (diff_s2),
		.level_s4 (green_s4)
	);

	hslrgb_channel u_blue (
		.clk      (clk),
		.en       (en),
		.pos      (pos_blue),
		.low_s2   (low_s2),
		.high_s2  (high_s2),
		.diff_s2  (diff_s2),
		.level_s4 (blue_s4)
	);

	assign rgb_valid = valid_s4;
	assign rgb.red   = red_s4;
	assign rgb.green = green_s4;
	assign rgb.blue  = blue_s4;

`ifndef SYNTHESIS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_ready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && !rgb_ready)
		else $error("input stalled while the pipeline has room");

	a_levels_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> low_s2 <= high_s2 && high_s2 <= ONE && diff_s2 == high_s2 - low_s2)
		else $error("level pair out of order");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> rgb.red <= ONE && rgb.green <= ONE && rgb.blue <= ONE)
		else $error("channel level above one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !en.s3 |=> valid_s3 && valid_s4)
		else $error("stalled transaction dropped");
`endif

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Streams pixels through the converter under random stalls on both sides and
// compares every RGB transaction with a fixed-point prediction of the same
// conversion, in order.
// ----------------------------------------------------------------------------

class rgb_ledger;

	hslrgb_pkg::rgb_t rgb_due[$];
	int mismatches;
	int pixels_in;
	int pixels_out;

	function new();
		mismatches = 0;
		pixels_in  = 0;
		pixels_out = 0;
	endfunction

	function int pending();
		return rgb_due.size();
	endfunction

	task report_mismatch(string what, longint got, longint want);
		$display("tb: mismatch on %s after %0d results: got %0d, want %0d",
			what, pixels_out, got, want);
		mismatches++;
	endtask

	function longint unit_clamp(longint v);
		longint one_v;
		one_v = longint'(hslrgb_pkg::ONE);
		if (v < 0)
			return 0;
		if (v > one_v)
			return one_v;
		return v;
	endfunction

	function longint hue_level(longint lo, longint hi, longint t);
		longint one_v;
		longint d;
		one_v = longint'(hslrgb_pkg::ONE);
		d = hi - lo;
		if (t < 0)
			t += one_v;
		if (t > one_v)
			t -= one_v;
		if (6 * t < one_v)
			return lo + ((d * (6 * t)) >> hslrgb_pkg::FRAC_BITS);
		if (2 * t < one_v)
			return hi;
		if (3 * t < 2 * one_v)
			return lo + ((d * (4 * one_v - 6 * t)) >> hslrgb_pkg::FRAC_BITS);
		return lo;
	endfunction

	function hslrgb_pkg::rgb_t hsl_to_rgb(hslrgb_pkg::hsl_t p);
		longint one_v, third_v, h, s, l, hi, lo;
		hslrgb_pkg::rgb_t c;
		one_v   = longint'(hslrgb_pkg::ONE);
		third_v = longint'(hslrgb_pkg::THIRD);
		h = longint'(p.hue);
		s = longint'(p.saturation);
		l = longint'(p.lightness);
		if (h > one_v)
			h = one_v;
		if (s > one_v)
			s = one_v;
		if (l > one_v)
			l = one_v;
		if (s == 0) begin
			c.red   = hslrgb_pkg::field_t'(l);
			c.green = hslrgb_pkg::field_t'(l);
			c.blue  = hslrgb_pkg::field_t'(l);
			return c;
		end
		if (l < longint'(hslrgb_pkg::HALF))
			hi = (l * (one_v + s)) >> hslrgb_pkg::FRAC_BITS;
		else
			hi = l + s - ((s * l) >> hslrgb_pkg::FRAC_BITS);
		hi = unit_clamp(hi);
		lo = unit_clamp(2 * l - hi);
		if (hi < lo)
			hi = lo;
		c.red   = hslrgb_pkg::field_t'(unit_clamp(hue_level(lo, hi, h + third_v)));
		c.green = hslrgb_pkg::field_t'(unit_clamp(hue_level(lo, hi, h)));
		c.blue  = hslrgb_pkg::field_t'(unit_clamp(hue_level(lo, hi, h - third_v)));
		return c;
	endfunction

	function void note_hsl(hslrgb_pkg::hsl_t p);
		rgb_due = {rgb_due, hsl_to_rgb(p)};
		pixels_in++;
	endfunction

	task check_rgb(hslrgb_pkg::rgb_t got);
		hslrgb_pkg::rgb_t want;
		if (rgb_due.size() == 0) begin
			report_mismatch("unexpected transaction", longint'(got), 0);
		end else begin
			want = rgb_due.pop_front();
			if (got.red !== want.red)
				report_mismatch("red", longint'(got.red), longint'(want.red));
			if (got.green !== want.green)
				report_mismatch("green", longint'(got.green), longint'(want.green));
			if (got.blue !== want.blue)
				report_mismatch("blue", longint'(got.blue), longint'(want.blue));
		end
		pixels_out++;
	endtask

endclass

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import hslrgb_pkg::*;

	localparam int RANDOM_PIXELS = 1400;
	localparam int HOLD_CYCLES   = 60;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic hsl_valid = 1'b0;
	logic hsl_ready;
	hsl_t hsl       = '0;
	logic rgb_valid;
	logic rgb_ready = 1'b0;
	rgb_t rgb;

	bit quiet        = 1'b0;
	bit hold_pending = 1'b0;
	int hold_left    = 0;
	int directed_cnt = 0;

	rgb_ledger ledger = new();

	hsl_to_rgb_converter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsl_valid(hsl_valid),
		.hsl_ready(hsl_ready),
		.hsl      (hsl),
		.rgb_valid(rgb_valid),
		.rgb_ready(rgb_ready),
		.rgb      (rgb)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic hsl_t pix(int unsigned h, int unsigned s, int unsigned l);
		hsl_t p;
		p.hue        = field_t'(h);
		p.saturation = field_t'(s);
		p.lightness  = field_t'(l);
		return p;
	endfunction

	function automatic field_t random_field();
		int unsigned one_v;
		one_v = int'(ONE);
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(7))
					0: return '0;
					1: return field_t'(1);
					2: return HALF - 1'b1;
					3: return HALF;
					4: return ONE - 1'b1;
					5: return ONE;
					6: return THIRD;
					default: return field_t'(2 * int'(THIRD));
				endcase
			end
			1: return field_t'($urandom_range(2 ** FIELD_W - 1));
			default: return field_t'($urandom_range(one_v));
		endcase
	endfunction

	function automatic hsl_t random_pixel();
		hsl_t p;
		p.hue        = random_field();
		p.saturation = random_field();
		p.lightness  = random_field();
		return p;
	endfunction

	task automatic send_pixel(input hsl_t p);
		hsl_valid <= 1'b1;
		hsl       <= p;
		do @(posedge clk); while (!hsl_ready);
		ledger.note_hsl(p);
	endtask

	task automatic send_directed(input hsl_t p);
		send_pixel(p);
		directed_cnt++;
	endtask

	// receiver: random back-pressure, quiet window and one long hold-off
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rgb_valid && rgb_ready)
				ledger.check_rgb(rgb);
			if (hold_left == 0 && hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rgb_ready <= 1'b0;
			end else if (quiet) begin
				rgb_ready <= 1'b1;
			end else begin
				rgb_ready <= ($urandom_range(99) >= 18);
			end
		end
	end

	initial begin
		int unsigned one_v, half_v, third_v, top_v;
		one_v   = int'(ONE);
		half_v  = int'(HALF);
		third_v = int'(THIRD);
		top_v   = 2 ** FIELD_W - 1;
		wait (arst_n === 1'b1);
		@(posedge clk);

		send_directed(pix(0, 0, 0));
		send_directed(pix(0, 0, one_v));
		send_directed(pix(one_v, 0, half_v));
		send_directed(pix(top_v, 0, top_v));
		send_directed(pix(0, one_v, half_v));
		send_directed(pix(third_v, one_v, half_v));
		send_directed(pix(2 * third_v, one_v, half_v));
		send_directed(pix(one_v, one_v, half_v));
		send_directed(pix(top_v, one_v, half_v));
		send_directed(pix(0, top_v, top_v));
		send_directed(pix(10922, one_v, half_v - 1));
		send_directed(pix(10923, one_v, half_v));
		send_directed(pix(32767, one_v, half_v));
		send_directed(pix(32768, one_v, half_v));
		send_directed(pix(43690, one_v, 20000));
		send_directed(pix(43691, one_v, 50000));
		send_directed(pix(1, 1, 0));
		send_directed(pix(1, 1, 1));
		send_directed(pix(54613, one_v, one_v));
		send_directed(pix(54613, one_v, one_v - 1));
		send_directed(pix(65535, 1, half_v - 1));
		send_directed(pix(top_v, top_v, 0));
		send_directed(pix(21845, 30000, 40000));
		send_directed(pix(one_v - 1, 12345, one_v - 1));

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			if (n == 300)
				hold_pending = 1'b1;
			if (n == 500)
				quiet = 1'b1;
			if (n == 800)
				quiet = 1'b0;
			if (n == 1000) begin
				hsl_valid <= 1'b0;
				do @(posedge clk); while (ledger.pending() != 0);
			end else if (!quiet && !hold_pending && hold_left == 0
					&& $urandom_range(99) < 15) begin
				hsl_valid <= 1'b0;
				repeat ($urandom_range(2, 1)) @(posedge clk);
			end
			send_pixel(random_pixel());
		end
		hsl_valid <= 1'b0;

		do @(posedge clk); while (ledger.pending() != 0);
		repeat (8) @(posedge clk);

		$display("tb: %0d pixels in, %0d out (%0d directed: gray, hues, edges, over-range)",
			ledger.pixels_in, ledger.pixels_out, directed_cnt);
		$display("tb: random back-pressure, a %0d-cycle output hold-off and a full drain pause",
			HOLD_CYCLES);
		if (ledger.mismatches == 0 && ledger.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/hslrgb_pkg.sv
rtl/core/hslrgb_level.sv
rtl/core/hslrgb_channel.sv
rtl/core/hsl_to_rgb_converter_unit.sv
test/testbench.sv
